// ----- src/rsw_pkg.sv -----
`timescale 1ns / 1ps
// Package for the received sequence window unit.
// Holds window sizing, mark codes, transaction types and the slot helper.
// Depends on nothing; the datapath modules in src import it.
package rsw_pkg;

	// Sequence and window sizing. The window depth must be a power of two.
	localparam int unsigned SEQ_W        = 16;
	localparam int unsigned WINDOW_DEPTH = 1024;
	localparam int unsigned SLOT_W       = $clog2(WINDOW_DEPTH);
	localparam int unsigned HALF_DEPTH   = WINDOW_DEPTH / 2;
	localparam int unsigned ACK_BITS     = 32;
	localparam int unsigned ACK_IDX_W    = $clog2(ACK_BITS) + 1;
	localparam int unsigned MARK_W       = 2;

	// Depth of the small queues at both ends of the block.
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

	// Sequence thresholds.
	localparam logic [SEQ_W-1:0] FORWARD_LIMIT = 16'h8000;
	localparam logic [SEQ_W-1:0] OVERRUN_LIMIT = SEQ_W'(WINDOW_DEPTH - ACK_BITS);
	localparam logic [SEQ_W-1:0] SEQ_RESET     = 16'hFFFF;

	// Mark codes: bit 0 is received, bit 1 is resent by a later packet.
	localparam logic [MARK_W-1:0] MARK_NONE     = 2'b00;
	localparam logic [MARK_W-1:0] MARK_RECEIVED = 2'b01;
	localparam logic [MARK_W-1:0] MARK_RESENT   = 2'b10;
	localparam logic [MARK_W-1:0] MARK_BOTH     = 2'b11;

	// One arriving sub-packet.
	typedef struct packed {
		logic [SEQ_W-1:0] seq_num;
		logic             is_resend;
		logic [SEQ_W-1:0] original_seq;
	} rsw_item_t;

	// Head of the input queue as seen by the engine, with slots precomputed.
	typedef struct packed {
		logic              valid;
		rsw_item_t         item;
		logic [SLOT_W-1:0] pos;
		logic [SLOT_W-1:0] rpos;
	} rsw_head_t;

	// One result transaction.
	typedef struct packed {
		logic                accepted;
		logic                overrun;
		logic [SEQ_W-1:0]    latest_seq;
		logic [ACK_BITS-1:0] ack_bitfield;
	} rsw_result_t;

	// Ring slot of a sequence number.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] seq);
		return seq[SLOT_W-1:0];
	endfunction

endpackage

// ----- src/received_sequence_window_unit.sv -----
`timescale 1ns / 1ps
// Received sequence window unit: receive-side sequence tracker for a datagram link.
// Each input transaction (push/full) carries seq_num, is_resend and original_seq.
// Each one yields exactly one result transaction (empty/pop) with accepted,
// overrun, latest_seq and a 32-bit ack_bitfield of the slots just below latest_seq.
// Items enter a two-entry input queue; a sequencer then works on one item at a
// time over a 1024 x 2-bit mark memory with one write and one read port.
// Per item, the sequencer first clears one slot for each slot stepped over on a
// forward jump (the jump distance, at most 992), then reads and checks the item's
// slot and its original's slot, writes the marks if accepted, and reads the 32
// ack bits one at a time over the read port. An overrun item skips the jump and
// the checks and goes straight to gathering the ack bits.
// After reset the unit sweeps the mark memory to zero and holds full high
// meanwhile; the highest sequence starts at 65535.
// Results wait in a two-entry queue. When the receiver stalls, the engine holds
// its finished result until there is room, and input transactions keep being
// queued until the input queue fills.
// Depends on rsw_pkg, rsw_front, rsw_engine and rsw_out_queue.
module received_sequence_window_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] seq_num,
	input  logic        is_resend,
	input  logic [15:0] original_seq,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic        overrun,
	output logic [15:0] latest_seq,
	output logic [31:0] ack_bitfield
);
	import rsw_pkg::*;

	rsw_item_t   item_in;
	rsw_head_t   head;
	logic        head_pop;
	logic        clearing;
	rsw_result_t result;
	logic        result_push;
	logic        result_full;
	rsw_result_t result_out;

	always_comb begin
		item_in.seq_num      = seq_num;
		item_in.is_resend    = is_resend;
		item_in.original_seq = original_seq;
	end

	// Input queue and slot decode.
	rsw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (item_in),
		.hold     (clearing),
		.full     (full),
		.head     (head),
		.head_pop (head_pop)
	);

	// Window sequencer and mark memory.
	rsw_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_pop    (head_pop),
		.clearing    (clearing),
		.result      (result),
		.result_push (result_push),
		.result_full (result_full)
	);

	// Result queue.
	rsw_out_queue u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (result_push),
		.result_in  (result),
		.full       (result_full),
		.empty      (empty),
		.pop        (pop),
		.result_out (result_out)
	);

	assign accepted     = result_out.accepted;
	assign overrun      = result_out.overrun;
	assign latest_seq   = result_out.latest_seq;
	assign ack_bitfield = result_out.ack_bitfield;

endmodule

// ----- src/rsw_front.sv -----
`timescale 1ns / 1ps
// Front end of the received sequence window unit: input queue and slot decode.
// Depends on rsw_pkg.
module rsw_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rsw_pkg::rsw_item_t item_in,
	input  logic              hold,
	output logic              full,
	output rsw_pkg::rsw_head_t head,
	input  logic              head_pop
);
	import rsw_pkg::*;

	rsw_item_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push_ok;
	logic              pop_ok;
	rsw_item_t         head_item;

	// No transaction is taken while the engine sweeps its mark memory.
	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH)) || hold;
	assign push_ok = push && !full;
	assign pop_ok  = head_pop && (count_q != '0);

	// Payload storage needs no reset.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			entries_q[wr_ptr_q] <= item_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	// Present the oldest item with its ring slots already decoded.
	always_comb begin
		head_item  = entries_q[rd_ptr_q];
		head.valid = (count_q != '0);
		head.item  = head_item;
		head.pos   = slot_of(head_item.seq_num);
		head.rpos  = slot_of(head_item.original_seq);
	end

endmodule

// ----- src/rsw_engine.sv -----
`timescale 1ns / 1ps
// Back end of the received sequence window unit: sequencer over the mark ring.
// Depends on rsw_pkg; holds the mark memory and the highest sequence register.
module rsw_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  rsw_pkg::rsw_head_t  head,
	output logic                head_pop,
	output logic                clearing,
	output rsw_pkg::rsw_result_t result,
	output logic                result_push,
	input  logic                result_full
);
	import rsw_pkg::*;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_JUMP,
		ST_RD_POS,
		ST_RD_ORIG,
		ST_CHECK,
		ST_WR_POS,
		ST_WR_ORIG,
		ST_ACK,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [SEQ_W-1:0]    highest_q;
	logic [SEQ_W-1:0]    seq_q;
	logic                resend_q;
	logic [SLOT_W-1:0]   pos_q;
	logic [SLOT_W-1:0]   rpos_q;
	logic [SLOT_W-1:0]   cursor_q;
	logic [ACK_IDX_W-1:0] ack_idx_q;
	logic [ACK_BITS-1:0] ack_q;
	logic                accepted_q;
	logic                overrun_q;
	logic [MARK_W-1:0]   pos_mark_q;

	logic [MARK_W-1:0]   marks_mem [WINDOW_DEPTH];
	logic [MARK_W-1:0]   rdata_q;
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_waddr;
	logic [MARK_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [SLOT_W-1:0]   mem_raddr;

	logic [SEQ_W-1:0]    diff;
	logic                is_forward;
	logic                is_overrun;
	logic [SLOT_W-1:0]   ack_base;
	logic [SLOT_W-1:0]   cursor_next;

	// Classification of the head item against the current highest sequence.
	assign diff        = head.item.seq_num - highest_q;
	assign is_forward  = (diff != '0) && (diff < FORWARD_LIMIT);
	assign is_overrun  = is_forward && (diff > OVERRUN_LIMIT);
	assign ack_base    = slot_of(highest_q) - SLOT_W'(1);
	assign cursor_next = cursor_q + SLOT_W'(1);

	assign head_pop    = (state_q == ST_IDLE) && head.valid;
	assign clearing    = (state_q == ST_INIT);
	assign result_push = (state_q == ST_OUT) && !result_full;

	always_comb begin
		result.accepted     = accepted_q;
		result.overrun      = overrun_q;
		result.latest_seq   = highest_q;
		result.ack_bitfield = ack_q;
	end

	// Memory port control for each step of the sequencer.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cursor_q;
		mem_wdata = MARK_NONE;
		mem_re    = 1'b0;
		mem_raddr = pos_q;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_JUMP: begin
				mem_we    = 1'b1;
				mem_waddr = cursor_q + SLOT_W'(HALF_DEPTH);
			end
			ST_RD_POS: begin
				mem_re = 1'b1;
			end
			ST_RD_ORIG: begin
				mem_re    = 1'b1;
				mem_raddr = rpos_q;
			end
			ST_WR_POS: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = MARK_RECEIVED;
			end
			ST_WR_ORIG: begin
				mem_we    = 1'b1;
				mem_waddr = rpos_q;
				mem_wdata = (rpos_q == pos_q) ? MARK_BOTH : MARK_RESENT;
			end
			ST_ACK: begin
				mem_re    = (ack_idx_q < ACK_IDX_W'(ACK_BITS));
				mem_raddr = ack_base - SLOT_W'(ack_idx_q);
			end
			default: begin
			end
		endcase
	end

	// Mark ring: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			marks_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= marks_mem[mem_raddr];
		end
	end

	// Sequencer state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			highest_q  <= SEQ_RESET;
			cursor_q   <= '0;
			ack_idx_q  <= '0;
			accepted_q <= 1'b0;
			overrun_q  <= 1'b0;
			resend_q   <= 1'b0;
		end else begin
			unique case (state_q)
				// Sweep the whole ring to zero after reset.
				ST_INIT: begin
					cursor_q <= cursor_next;
					if (cursor_q == SLOT_W'(WINDOW_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						seq_q      <= head.item.seq_num;
						resend_q   <= head.item.is_resend;
						pos_q      <= head.pos;
						rpos_q     <= head.rpos;
						overrun_q  <= is_overrun;
						accepted_q <= 1'b0;
						cursor_q   <= slot_of(highest_q);
						ack_idx_q  <= '0;
						if (is_overrun) begin
							state_q <= ST_ACK;
						end else if (is_forward) begin
							state_q <= ST_JUMP;
						end else begin
							state_q <= ST_RD_POS;
						end
					end
				end
				// Clear half a window ahead of each slot stepped over.
				ST_JUMP: begin
					cursor_q <= cursor_next;
					if (cursor_next == pos_q) begin
						highest_q <= seq_q;
						state_q   <= ST_RD_POS;
					end
				end
				ST_RD_POS: begin
					state_q <= ST_RD_ORIG;
				end
				ST_RD_ORIG: begin
					pos_mark_q <= rdata_q;
					state_q    <= ST_CHECK;
				end
				// Duplicate when the item's slot already carries a mark, or, for a resend, the original's slot does.
				ST_CHECK: begin
					if ((pos_mark_q == MARK_NONE) && !(resend_q && (rdata_q != MARK_NONE))) begin
						accepted_q <= 1'b1;
						state_q    <= ST_WR_POS;
					end else begin
						state_q <= ST_ACK;
					end
				end
				ST_WR_POS: begin
					state_q <= resend_q ? ST_WR_ORIG : ST_ACK;
				end
				ST_WR_ORIG: begin
					state_q <= ST_ACK;
				end
				// Gather ack bits; read data is registered, so each bit is shifted in behind its address.
				ST_ACK: begin
					if (ack_idx_q != '0) begin
						ack_q <= {rdata_q[0], ack_q[ACK_BITS-1:1]};
					end
					ack_idx_q <= ack_idx_q + ACK_IDX_W'(1);
					if (ack_idx_q == ACK_IDX_W'(ACK_BITS)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!result_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/rsw_out_queue.sv -----
`timescale 1ns / 1ps
// Result queue of the received sequence window unit.
// Depends on rsw_pkg; parts the engine from the receiver of results.
module rsw_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rsw_pkg::rsw_result_t result_in,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output rsw_pkg::rsw_result_t result_out
);
	import rsw_pkg::*;

	rsw_result_t       entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push_ok;
	logic              pop_ok;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);
	assign push_ok    = push && !full;
	assign pop_ok     = pop && !empty;
	assign result_out = entries_q[rd_ptr_q];

	// Payload storage needs no reset.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			entries_q[wr_ptr_q] <= result_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- src/rsw_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the received sequence window unit.
// Depends on the top level's ports only; bound to received_sequence_window_unit.
module rsw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        accepted,
	input logic        overrun,
	input logic [15:0] latest_seq,
	input logic [31:0] ack_bitfield
);

	// An overrun transaction is never also accepted.
	a_overrun_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(accepted && overrun))
		else $error("result reports both accepted and overrun");

	// The memory sweep after reset blocks input in the first cycle out of reset.
	a_full_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> full)
		else $error("input not held off during the post-reset sweep");

	// Nothing can be waiting right after reset, since no transaction came in.
	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> empty)
		else $error("result present right after reset");

	// A waiting result holds while the receiver stalls.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(latest_seq) && $stable(ack_bitfield)
			&& $stable(accepted) && $stable(overrun)))
		else $error("stalled result changed");

endmodule

bind received_sequence_window_unit rsw_checker u_rsw_checker (.*);

// ----- sim/received_sequence_window_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the received sequence window unit: directed and random packets
// against a sequence-window scoreboard. Depends on rsw_pkg and received_sequence_window_unit.
module received_sequence_window_unit_test;
	import rsw_pkg::*;

	// Cycles to keep watching the result side after the last expected transaction.
	localparam int unsigned DRAIN_CYCLES = 1100;

	// Scoreboard: tracks the window state and queues the ack each packet should produce.
	class seq_window_scoreboard;
		logic [SEQ_W-1:0]  highest_seq;
		logic [MARK_W-1:0] slot_marks [WINDOW_DEPTH];
		rsw_result_t       awaited_acks [$];
		int                mismatches;

		function new();
			highest_seq = SEQ_RESET;
			foreach (slot_marks[k]) slot_marks[k] = MARK_NONE;
			mismatches = 0;
		endfunction

		// Apply one packet taken by the unit to the window and queue the ack it causes.
		function void note_packet(input logic [SEQ_W-1:0] seq, input logic resend,
			input logic [SEQ_W-1:0] orig);
			logic [SEQ_W-1:0] diff;
			logic [SEQ_W-1:0] below;
			int unsigned      pos;
			int unsigned      rpos;
			int unsigned      k;
			rsw_result_t      res;
			pos  = seq % WINDOW_DEPTH;
			rpos = orig % WINDOW_DEPTH;
			diff = seq - highest_seq;
			res  = '0;
			if (diff != 0 && diff < FORWARD_LIMIT && diff > OVERRUN_LIMIT) begin
				res.overrun = 1'b1;
			end else begin
				// A forward jump clears the slots half a window ahead of each step.
				if (diff != 0 && diff < FORWARD_LIMIT) begin
					k = highest_seq % WINDOW_DEPTH;
					while (k != pos) begin
						slot_marks[(k + HALF_DEPTH) % WINDOW_DEPTH] = MARK_NONE;
						k = (k + 1) % WINDOW_DEPTH;
					end
					highest_seq = seq;
				end
				// A mark on the packet's slot, or for a resend on its original's slot, makes a duplicate.
				if (slot_marks[pos] == MARK_NONE &&
					!(resend && slot_marks[rpos] != MARK_NONE)) begin
					slot_marks[pos] |= MARK_RECEIVED;
					if (resend) begin
						slot_marks[rpos] |= MARK_RESENT;
					end
					res.accepted = 1'b1;
				end
			end
			res.latest_seq = highest_seq;
			for (k = 0; k < ACK_BITS; k++) begin
				below = highest_seq - 1'b1 - k[SEQ_W-1:0];
				res.ack_bitfield[k] =
					(slot_marks[below % WINDOW_DEPTH] & MARK_RECEIVED) != MARK_NONE;
			end
			awaited_acks.insert(awaited_acks.size(), res);
		endfunction

		// Compare one result transaction with the oldest queued ack.
		function void check_ack(input logic acc, input logic ovr,
			input logic [SEQ_W-1:0] lat, input logic [ACK_BITS-1:0] ack);
			rsw_result_t want;
			if (awaited_acks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: unexpected result accepted=%0b overrun=%0b latest_seq=%h ack=%h",
						$realtime, acc, ovr, lat, ack);
				end
				return;
			end
			want = awaited_acks[0];
			awaited_acks.delete(0);
			if (acc !== want.accepted || ovr !== want.overrun ||
				lat !== want.latest_seq || ack !== want.ack_bitfield) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: ack mismatch: expected accepted=%0b overrun=%0b latest_seq=%h ack=%h",
						$realtime, want.accepted, want.overrun, want.latest_seq,
						want.ack_bitfield);
					$display("%0t:                actual accepted=%0b overrun=%0b latest_seq=%h ack=%h",
						$realtime, acc, ovr, lat, ack);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [15:0] seq_num;
	logic        is_resend;
	logic [15:0] original_seq;
	logic        empty;
	logic        pop;
	logic        accepted;
	logic        overrun;
	logic [15:0] latest_seq;
	logic [31:0] ack_bitfield;

	int unsigned send_idle_pct;
	int unsigned pop_stall_pct;
	int unsigned send_idle_by_phase [4] = '{0, 69, 0, 19};
	int unsigned pop_stall_by_phase [4] = '{0, 0, 69, 19};

	seq_window_scoreboard sb = new();

	received_sequence_window_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.seq_num      (seq_num),
		.is_resend    (is_resend),
		.original_seq (original_seq),
		.empty        (empty),
		.pop          (pop),
		.accepted     (accepted),
		.overrun      (overrun),
		.latest_seq   (latest_seq),
		.ack_bitfield (ack_bitfield)
	);

	// Free-running clock, 4 ns period.
	always #2 clk = ~clk;

	// Result side: check each popped transaction, then decide whether to stall.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			sb.check_ack(accepted, overrun, latest_seq, ack_bitfield);
		end
		pop <= arst_n && ($urandom_range(0, 99) >= pop_stall_pct);
	end

	// Offer one packet, idling first at random, and return once the transaction is taken.
	task automatic send_packet(input logic [15:0] s, input logic rs, input logic [15:0] o);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		seq_num      <= s;
		is_resend    <= rs;
		original_seq <= o;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_packet(s, rs, o);
	endtask

	// Directed packets: field extremes, duplicates, resends, jump limits and overruns.
	task automatic run_directed();
		send_packet(16'h0000, 1'b0, 16'hFFFF);              // first step forward from reset
		send_packet(16'h0000, 1'b0, 16'h0000);              // plain duplicate
		send_packet(16'hFFFF, 1'b0, 16'h1234);              // older sequence, slot unmarked
		send_packet(16'h0001, 1'b1, 16'h0000);              // resend of a received original
		send_packet(16'h0002, 1'b1, 16'h0005);              // resend of a missing original
		send_packet(16'h0005, 1'b0, 16'h0000);              // slot holds only the resent mark
		send_packet(16'h0003, 1'b1, 16'h0006);
		send_packet(16'h0006, 1'b0, 16'h0000);              // jump onto a resent slot
		send_packet(sb.highest_seq + OVERRUN_LIMIT, 1'b0, 16'h0000);   // largest legal jump
		send_packet(sb.highest_seq + OVERRUN_LIMIT + 1'b1, 1'b1, 16'hFFFF); // just overrun
		send_packet(sb.highest_seq + 16'h7FFF, 1'b0, 16'h0000);        // farthest forward
		send_packet(sb.highest_seq + FORWARD_LIMIT, 1'b0, 16'h0000);   // half-range back
		send_packet(16'hFFFF, 1'b1, 16'hFFFF);
		send_packet(16'h0000, 1'b1, 16'h0000);
		send_packet(16'hAAAA, 1'b0, 16'h5555);
		send_packet(16'h5555, 1'b1, 16'hAAAA);
		send_packet(sb.highest_seq + 16'(HALF_DEPTH), 1'b0, 16'h0000); // half-window jump
		send_packet(sb.highest_seq + 16'd1, 1'b1, sb.highest_seq - 16'd1);
		send_packet(sb.highest_seq, 1'b0, 16'h0000);                   // equal sequence
		send_packet(sb.highest_seq + 16'd31, 1'b0, 16'h0000);
		send_packet(sb.highest_seq + 16'd32, 1'b1, sb.highest_seq + 16'd40);
		send_packet(sb.highest_seq + 16'd8, 1'b0, 16'h0000);           // was resent ahead
	endtask

	// One random packet, mostly near the current window so the ring gets real traffic.
	task automatic send_random_packet();
		logic [15:0] top;
		logic [15:0] s;
		logic [15:0] o;
		logic        rs;
		int unsigned pick;
		top  = sb.highest_seq;
		o    = 16'($urandom);
		rs   = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			s  = top + 16'($urandom_range(1, 4));
			rs = ($urandom_range(0, 4) == 0);
			if (rs) begin
				o = top - 16'($urandom_range(0, 40));
			end
		end else if (pick < 45) begin
			s  = top + 16'($urandom_range(0, 3));
			rs = 1'b1;
			o  = $urandom_range(0, 1) ? top - 16'($urandom_range(0, 63))
			                          : top + 16'($urandom_range(1, 40));
		end else if (pick < 60) begin
			s = top - 16'($urandom_range(0, 50));
		end else if (pick < 70) begin
			s = top + 16'($urandom_range(5, 200));
		end else if (pick < 80) begin
			s = top + (($urandom_range(0, 7) == 0) ? OVERRUN_LIMIT
			                                       : 16'($urandom_range(700, OVERRUN_LIMIT)));
		end else if (pick < 87) begin
			s = top + (($urandom_range(0, 3) == 0) ? OVERRUN_LIMIT + 1'b1
			          : 16'($urandom_range(OVERRUN_LIMIT + 1, 16'h7FFF)));
		end else if (pick < 92) begin
			s = top + 16'($urandom_range(FORWARD_LIMIT, 16'hFFFF));
		end else begin
			s  = 16'($urandom);
			rs = 1'($urandom_range(0, 1));
		end
		send_packet(s, rs, o);
	endtask

	// Main sequence: reset, directed packets, random phases, drain and verdict.
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		push          = 1'b0;
		seq_num       = '0;
		is_resend     = 1'b0;
		original_seq  = '0;
		pop           = 1'b0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_idle_by_phase[phase];
			pop_stall_pct = pop_stall_by_phase[phase];
			repeat (200) send_random_packet();
		end
		push <= 1'b0;
		while (sb.awaited_acks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited_acks.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
